@@ rtl/sliding_median_adc_filter_macros.svh @@
// Assertion macros used by the checker file.
`ifndef SLIDING_MEDIAN_ADC_FILTER_MACROS_SVH
`define SLIDING_MEDIAN_ADC_FILTER_MACROS_SVH

// Next-cycle implication, suspended while reset is high.
`define SMAF_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("smaf assertion failed");

// Next-cycle implication, checked during reset as well.
`define SMAF_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("smaf assertion failed");

`endif

@@ rtl/smaf_pkg.sv @@
`default_nettype none
package smaf_pkg;

   localparam int WINDOW   = 5;
   localparam int RAW_W    = 26;
   localparam int SAMPLE_W = 24;
   localparam int SLOT_W   = $clog2(WINDOW);
   localparam int CNT_W    = $clog2(WINDOW + 1);
   localparam int BIT_W    = $clog2(SAMPLE_W);
   localparam int RANK     = (WINDOW - 1) / 2;

   localparam logic [SAMPLE_W-1:0] SIGN_FLIP = SAMPLE_W'(24'h800000);

   // sequencing strobes from the top level to the ring and the selector
   typedef struct packed {
      logic load;   // new sample written, selector restarted
      logic step;   // one bit position processed, ring rotates
   } seq_ctrl_type;

endpackage
`default_nettype wire

@@ rtl/smaf_ring.sv @@
`default_nettype none
module smaf_ring
   import smaf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire seq_ctrl_type        ctrl,
   input  wire logic [SAMPLE_W-1:0] wr_sample,
   output logic      [WINDOW-1:0]   msb_bits
);

   logic [SAMPLE_W-1:0] entries_ff [WINDOW];
   logic [SAMPLE_W-1:0] entries_in [WINDOW];
   logic [SLOT_W-1:0]   slot_ff;
   logic [SLOT_W-1:0]   slot_in;

   always_comb begin
      for (int i = 0; i < WINDOW; i++) begin
         entries_in[i] = entries_ff[i];
         // circular rotate: after SAMPLE_W steps each entry is back in place
         if (ctrl.step) begin
            entries_in[i] = {entries_ff[i][SAMPLE_W-2:0], entries_ff[i][SAMPLE_W-1]};
         end
         if (ctrl.load && slot_ff == SLOT_W'(i)) begin
            entries_in[i] = wr_sample;
         end
         msb_bits[i] = entries_ff[i][SAMPLE_W-1];
      end
   end

   always_comb begin
      slot_in = slot_ff;
      if (ctrl.load) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : SLOT_W'(slot_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         for (int i = 0; i < WINDOW; i++) begin
            entries_ff[i] <= '0;
         end
      end else begin
         slot_ff <= slot_in;
         for (int i = 0; i < WINDOW; i++) begin
            entries_ff[i] <= entries_in[i];
         end
      end
   end

endmodule
`default_nettype wire

@@ rtl/smaf_rank_sel.sv @@
`default_nettype none
module smaf_rank_sel
   import smaf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire seq_ctrl_type        ctrl,
   input  wire logic [WINDOW-1:0]   msb_bits,
   output logic      [SAMPLE_W-1:0] result
);

   logic [WINDOW-1:0]   active_ff;
   logic [WINDOW-1:0]   active_in;
   logic [CNT_W-1:0]    rank_ff;
   logic [CNT_W-1:0]    rank_in;
   logic [SAMPLE_W-1:0] result_ff;
   logic [SAMPLE_W-1:0] result_in;
   logic [WINDOW-1:0]   zeros;
   logic [CNT_W-1:0]    zero_cnt;
   logic                res_bit;

   // MSB-first radix select: the wanted rank lies among the zeros or the ones
   assign zeros    = active_ff & ~msb_bits;
   assign zero_cnt = CNT_W'($countones(zeros));
   assign res_bit  = (rank_ff >= zero_cnt);

   always_comb begin
      active_in = active_ff;
      rank_in   = rank_ff;
      result_in = result_ff;
      if (ctrl.load) begin
         active_in = '1;
         rank_in   = CNT_W'(RANK);
      end else if (ctrl.step) begin
         result_in = {result_ff[SAMPLE_W-2:0], res_bit};
         if (res_bit) begin
            active_in = active_ff & msb_bits;
            rank_in   = CNT_W'(rank_ff - zero_cnt);
         end else begin
            active_in = zeros;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         rank_ff   <= '0;
      end else begin
         active_ff <= active_in;
         rank_ff   <= rank_in;
      end
      result_ff <= result_in;
   end

   assign result = result_ff;

endmodule
`default_nettype wire

@@ rtl/sliding_median_adc_filter.sv @@
// A word is taken in ST_IDLE, stepped through every bit position in ST_RUN, and waits in
// ST_DONE until the output register is free; no new word is taken before then. The bit-serial
// rank select walks one bit position of all ring entries per cycle, MSB first.
// req_stall stays high from acceptance until the result enters the output register.
// Reset (synchronous, active high) clears the ring, the write slot, the last
// median and the output valid; the block takes a word in the first cycle after.
`default_nettype none
module sliding_median_adc_filter
   import smaf_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire logic [RAW_W-1:0]    req_raw_bits,
   input  wire logic                req_read_failed,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   output logic      [SAMPLE_W-1:0] rsp_median
);

   // control states
   localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a word
   localparam logic [1:0] ST_RUN  = 2'd1;   // stepping through bit positions
   localparam logic [1:0] ST_DONE = 2'd2;   // result held until output register frees

   logic [1:0]          state_ff;
   logic [1:0]          state_in;
   logic [BIT_W-1:0]    bit_cnt_ff;
   logic [BIT_W-1:0]    bit_cnt_in;
   logic [SAMPLE_W-1:0] last_median_ff;
   logic [SAMPLE_W-1:0] last_median_in;
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [SAMPLE_W-1:0] rsp_median_ff;
   logic [SAMPLE_W-1:0] rsp_median_in;

   logic                accept;
   logic                out_free;
   logic [SAMPLE_W-1:0] sample;
   logic [WINDOW-1:0]   msb_bits;
   logic [SAMPLE_W-1:0] sel_result;
   seq_ctrl_type        ctrl;

   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // drop the last received bit, keep 24, flip the sign into offset binary;
   // a failed read repeats the previous median
   assign sample = req_read_failed ? last_median_ff
                                   : (req_raw_bits[SAMPLE_W:1] ^ SIGN_FLIP);

   assign ctrl.load = accept;
   assign ctrl.step = (state_ff == ST_RUN);

   smaf_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (ctrl),
      .wr_sample (sample),
      .msb_bits  (msb_bits)
   );

   smaf_rank_sel u_rank_sel (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (ctrl),
      .msb_bits (msb_bits),
      .result   (sel_result)
   );

   always_comb begin
      state_in       = state_ff;
      bit_cnt_in     = bit_cnt_ff;
      last_median_in = last_median_ff;
      rsp_median_in  = rsp_median_ff;
      // a taken word frees the output register
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in   = ST_RUN;
               bit_cnt_in = '0;
            end
         end
         ST_RUN: begin
            bit_cnt_in = BIT_W'(bit_cnt_ff + 1'b1);
            if (bit_cnt_ff == BIT_W'(SAMPLE_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_median_in  = sel_result;
               rsp_valid_in   = 1'b1;
               last_median_in = sel_result;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bit_cnt_ff     <= '0;
         last_median_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bit_cnt_ff     <= bit_cnt_in;
         last_median_ff <= last_median_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_median_ff <= rsp_median_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_median = rsp_median_ff;

endmodule
`default_nettype wire

@@ rtl/smaf_checker.sv @@
`default_nettype none
`include "sliding_median_adc_filter_macros.svh"
module smaf_checker
   import smaf_pkg::*;
(
   input wire logic                clock,
   input wire logic                reset,
   input wire logic                req_valid,
   input wire logic                req_stall,
   input wire logic [RAW_W-1:0]    req_raw_bits,
   input wire logic                req_read_failed,
   input wire logic                rsp_valid,
   input wire logic                rsp_stall,
   input wire logic [SAMPLE_W-1:0] rsp_median
);

   logic [RAW_W:0] req_word;

   assign req_word = {req_raw_bits, req_read_failed};

   // held output word stays put
   `SMAF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_median))
   // stalled input word stays put
   `SMAF_ASSERT_NEXT(a_req_hold, clock, reset, req_valid && req_stall, req_valid && $stable(req_word))
   // one word in flight: busy right after acceptance
   `SMAF_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall)
   // reset leaves the block empty and ready
   `SMAF_ASSERT_NEXT_ALWAYS(a_reset_empty, clock, reset, !rsp_valid && !req_stall)

endmodule

bind sliding_median_adc_filter smaf_checker u_smaf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_stall       (req_stall),
   .req_raw_bits    (req_raw_bits),
   .req_read_failed (req_read_failed),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_median      (rsp_median)
);
`default_nettype wire

@@ tb/sv/tb_sliding_median_adc_filter.sv @@
`timescale 1ns / 100ps

module tb_sliding_median_adc_filter;
   import smaf_pkg::*;

   // This settle time covers a word's latency with margin.
   localparam int SETTLE_CYCLES = 40;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [RAW_W-1:0]    req_raw_bits = '0;
   logic                req_read_failed = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [SAMPLE_W-1:0] rsp_median;

   sliding_median_adc_filter u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_raw_bits    (req_raw_bits),
      .req_read_failed (req_read_failed),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_median      (rsp_median)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Filter model: sample ring, write slot and last median.
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] model_ring [WINDOW] = '{default: '0};
   int                  model_slot   = 0;
   logic [SAMPLE_W-1:0] model_median = '0;

   logic [SAMPLE_W-1:0] pending_medians [$];
   int                  mismatch_count = 0;

   // Advance the filter by one converter word and return the new median.
   function automatic logic [SAMPLE_W-1:0] advance_filter_median(
      input logic [RAW_W-1:0] raw,
      input logic             failed
   );
      logic [SAMPLE_W-1:0] sorted [WINDOW];
      logic [SAMPLE_W-1:0] pick;
      logic [SAMPLE_W-1:0] sample;
      int                  i;
      int                  j;
      // failed read reuses the last median; otherwise drop LSB, flip sign
      if (failed) begin
         sample = model_median;
      end else begin
         sample = raw[SAMPLE_W:1] ^ SIGN_FLIP;
      end
      model_ring[model_slot] = sample;
      model_slot = (model_slot == WINDOW - 1) ? 0 : model_slot + 1;
      sorted = model_ring;
      for (i = 1; i < WINDOW; i++) begin
         pick = sorted[i];
         j = i - 1;
         while (j >= 0 && sorted[j] > pick) begin
            sorted[j + 1] = sorted[j];
            j--;
         end
         sorted[j + 1] = pick;
      end
      model_median = sorted[RANK];
      return model_median;
   endfunction

   // Converter word that decodes to a given offset-binary sample; the two
   // dropped bits (top and LSB) are random.
   function automatic logic [RAW_W-1:0] raw_for_sample(input logic [SAMPLE_W-1:0] sample);
      return {1'($urandom_range(1)), sample ^ SIGN_FLIP, 1'($urandom_range(1))};
   endfunction

   // ---------------------------------------------------------------------
   // Result checker: every accepted word against the oldest prediction.
   // ---------------------------------------------------------------------
   logic [SAMPLE_W-1:0] want_median;

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_medians.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual median %h",
                     $time, rsp_median);
            mismatch_count++;
         end else begin
            want_median = pending_medians.pop_front();
            if (rsp_median !== want_median) begin
               $display("%0t: median mismatch, expected %h, actual %h",
                        $time, want_median, rsp_median);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver: stall rate changes in phases of random length (some with no
   // stalls at all); a long hold can be requested by a test.
   // ---------------------------------------------------------------------
   int hold_request = 0;
   int hold_left    = 0;
   int phase_left   = 0;
   int stall_pct    = 0;

   always @(negedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left != 0) begin
         rsp_stall = 1'b1;
         hold_left--;
      end else begin
         if (phase_left == 0) begin
            case ($urandom_range(4))
               0, 1: stall_pct = 0;
               2:    stall_pct = 20;
               3:    stall_pct = 50;
               default: stall_pct = 85;
            endcase
            phase_left = $urandom_range(150, 8);
         end
         phase_left--;
         rsp_stall = ($urandom_range(99) < stall_pct);
      end
   end

   // ---------------------------------------------------------------------
   // Sender helpers. Called and returning at a falling edge.
   // ---------------------------------------------------------------------
   task automatic send_word(input logic [RAW_W-1:0] raw, input logic failed);
      req_raw_bits = raw;
      req_read_failed = failed;
      req_valid = 1'b1;
      do @(posedge clock); while (req_stall);
      pending_medians.push_back(advance_filter_median(raw, failed));
      @(negedge clock);
   endtask

   task automatic pause_sender(input int cycles);
      if (cycles > 0) begin
         req_valid = 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   task automatic wait_all_results();
      req_valid = 1'b0;
      while (pending_medians.size() != 0) @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Ring starts all zero, so the first medians pull in zero entries.
   task automatic test_early_medians();
      send_word(26'h0FFFFFE, 1'b0);   // sample FFFFFF
      send_word(26'h3FFFFFF, 1'b0);   // sample 7FFFFF
      pause_sender(3);
      send_word(26'h1000000, 1'b0);   // sample 000000
      send_word(26'h0000000, 1'b0);   // sample 800000
      send_word(26'h2000001, 1'b0);   // dropped bits only
   endtask

   // Field extremes and alternating bit patterns.
   task automatic test_field_extremes();
      send_word(26'h1FFFFFE, 1'b0);
      send_word(26'h2000000, 1'b0);
      pause_sender(1);
      send_word(26'h0FFFFFF, 1'b0);
      send_word(26'h0000001, 1'b0);
      send_word(26'h3000000, 1'b0);
      pause_sender(7);
      send_word(26'h2AAAAAA, 1'b0);
      send_word(26'h1555555, 1'b0);
   endtask

   // Failed reads ignore the raw bits and feed back the last median.
   task automatic test_failed_reads();
      send_word(26'h3FFFFFF, 1'b1);
      send_word(26'h0000000, 1'b1);
      send_word(26'h2AAAAAA, 1'b1);
      pause_sender(2);
      send_word(26'h0C00000, 1'b0);
      send_word(26'h1555555, 1'b1);
   endtask

   // Six ascending samples back to back: write slot wraps past the last entry.
   task automatic test_slot_wrap();
      for (int k = 0; k < WINDOW + 1; k++) begin
         send_word(raw_for_sample(SAMPLE_W'(24'h100000 * (k + 1))), 1'b0);
      end
   endtask

   // Receiver holds off for a long stretch while words keep coming, so the
   // block fills and stalls its input; then the sender waits for a drain.
   task automatic test_output_backpressure();
      hold_request = 300;
      for (int k = 0; k < 8; k++) begin
         send_word(26'($urandom), 1'($urandom_range(1)));
      end
      wait_all_results();
   endtask

   // Mostly a slowly drifting load level with small noise, plus full-range
   // words, ties between a few values and runs of failed reads.
   task automatic test_random_stream(input int count);
      logic [SAMPLE_W-1:0] level;
      logic [SAMPLE_W-1:0] sample;
      logic [RAW_W-1:0]    raw;
      logic                failed;
      int                  burst_left;
      int                  fail_run;
      int                  roll;
      level = 24'h800000;
      burst_left = 0;
      fail_run = 0;
      for (int n = 0; n < count; n++) begin
         if (burst_left == 0) begin
            pause_sender(($urandom_range(3) == 0) ? 0 : $urandom_range(40, 1));
            burst_left = $urandom_range(20, 1);
         end
         burst_left--;
         if (n % 160 == 159) begin
            wait_all_results();
         end
         if ($urandom_range(49) == 0) begin
            case ($urandom_range(3))
               0: level = 24'h000010;
               1: level = 24'hFFFFF0;
               default: level = 24'($urandom);
            endcase
         end
         roll = $urandom_range(99);
         failed = 1'b0;
         if (fail_run != 0) begin
            fail_run--;
            failed = 1'b1;
            raw = 26'($urandom);
         end else if (roll < 8) begin
            failed = 1'b1;
            fail_run = ($urandom_range(4) == 0) ? $urandom_range(4, 1) : 0;
            raw = 26'($urandom);
         end else if (roll < 38) begin
            raw = 26'($urandom);
         end else if (roll < 85) begin
            sample = level + SAMPLE_W'($urandom_range(64)) - SAMPLE_W'(32);
            raw = raw_for_sample(sample);
         end else begin
            case ($urandom_range(4))
               0: sample = '0;
               1: sample = '1;
               2: sample = SIGN_FLIP;
               3: sample = SIGN_FLIP - 1'b1;
               default: sample = level;
            endcase
            raw = raw_for_sample(sample);
         end
         send_word(raw, failed);
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      reset = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_early_medians();
      test_field_extremes();
      test_failed_reads();
      test_slot_wrap();
      test_output_backpressure();
      test_random_stream(620);

      wait_all_results();
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

   // Run limit, several times the slowest expected run.
   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

endmodule
